>>> rtl/dsbr_pkg.sv
// Shared constants, payload structs and queue entry type for the DRRIP
// replacement core with per-set stream bypass. No dependencies.
`default_nettype none

package dsbr_pkg;

    // Geometry
    localparam int SET_COUNT    = 2048;
    localparam int SET_W        = $clog2(SET_COUNT);
    localparam int WAY_COUNT    = 16;
    localparam int WAY_W        = $clog2(WAY_COUNT);
    localparam int RRPV_W       = 2;
    localparam int SEL_W        = 10;
    localparam int LEADER_COUNT = 64;
    localparam int LEAD_HALF    = LEADER_COUNT / 2;
    localparam int WINDOW_BITS  = 20;
    localparam int STREAK_W     = 4;
    localparam int BIM_W        = 5;      // throttle period 32
    localparam int THR_W        = 3;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    localparam logic [RRPV_W-1:0]   RRPV_TOP   = '1;
    localparam logic [RRPV_W-1:0]   RRPV_LONG  = RRPV_TOP - RRPV_W'(1);
    localparam logic [RRPV_W-1:0]   RRPV_NEAR  = '0;
    localparam logic [SEL_W-1:0]    SEL_TOP    = '1;
    localparam logic [SEL_W-1:0]    SEL_MID    = SEL_TOP / 2;
    localparam logic [STREAK_W-1:0] STREAK_TOP = '1;
    localparam logic [THR_W-1:0]    THR_RESET  = THR_W'(4);

    typedef struct packed {
        logic [10:0] set_index;
        logic [19:0] address_low;
        logic        is_hit;
        logic [3:0]  hit_way;
    } t_in_item;

    typedef struct packed {
        logic [3:0] chosen_way;
        logic [1:0] inserted_rrpv;
        logic       streaming_seen;
    } t_out_item;

    typedef enum logic [1:0] {
        CLS_FOLLOW,
        CLS_SRRIP_LEAD,
        CLS_BRRIP_LEAD
    } t_class;

    typedef struct packed {
        logic [SET_W-1:0]       set;
        logic [WINDOW_BITS-1:0] addr;
        logic                   is_hit;
        logic [WAY_W-1:0]       way;
        t_class                 cls;
    } t_q_entry;

    typedef struct packed {
        logic [WINDOW_BITS-1:0] last_addr;
        logic [WINDOW_BITS-1:0] last_stride;
        logic [STREAK_W-1:0]    streak;
    } t_det;

    typedef logic [WAY_COUNT-1:0][RRPV_W-1:0] t_rrpv_row;

endpackage

`default_nettype wire

>>> rtl/dsbr_front.sv
// Front end: takes requests, trims set/way/address, tags leader class.
// Depends on dsbr_pkg; feeds dsbr_queue.
`default_nettype none

module dsbr_front (
    input  wire                dsbr_pkg::t_in_item i_in_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire                i_q_full,
    input  wire                i_clearing,
    output logic               o_push,
    output dsbr_pkg::t_q_entry o_entry
);
    import dsbr_pkg::*;

    logic [SET_W-1:0] set;

    assign set        = i_in_data.set_index[SET_W-1:0];
    assign o_in_stall = i_q_full | i_clearing;
    assign o_push     = i_in_valid & ~o_in_stall;

    always_comb begin
        o_entry        = '0;
        o_entry.set    = set;
        o_entry.addr   = i_in_data.address_low[WINDOW_BITS-1:0];
        o_entry.is_hit = i_in_data.is_hit;
        o_entry.way    = i_in_data.hit_way[WAY_W-1:0];
        if (set < SET_W'(LEAD_HALF)) begin
            o_entry.cls = CLS_SRRIP_LEAD;
        end else if (set < SET_W'(LEADER_COUNT)) begin
            o_entry.cls = CLS_BRRIP_LEAD;
        end else begin
            o_entry.cls = CLS_FOLLOW;
        end
    end

endmodule

`default_nettype wire

>>> rtl/dsbr_queue.sv
// Two-entry FIFO between front and back ends.
// Depends on dsbr_pkg.
`default_nettype none

module dsbr_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  wire                dsbr_pkg::t_q_entry i_entry,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_valid,
    output dsbr_pkg::t_q_entry o_entry
);
    import dsbr_pkg::*;

    t_q_entry             r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr, r_rptr;
    logic [Q_CNT_W-1:0]   r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/dsbr_back.sv
// Back end: RRPV and stride-detector memories, victim pick, insertion policy,
// selector and throttle counter, output register. Depends on dsbr_pkg.
`default_nettype none

module dsbr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [dsbr_pkg::THR_W-1:0] i_cfg_wdata,
    input  wire                 i_q_valid,
    input  wire                 dsbr_pkg::t_q_entry i_q_entry,
    output logic                o_q_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output dsbr_pkg::t_out_item o_out_data
);
    import dsbr_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC
    } t_state;

    t_state             r_state, n_state;
    logic [SET_W-1:0]   r_clr_idx, n_clr_idx;
    t_q_entry           r_item, n_item;
    logic [SEL_W-1:0]   r_sel, n_sel;
    logic [BIM_W-1:0]   r_bim, n_bim;
    logic [THR_W-1:0]   r_thr;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    t_rrpv_row          r_rrpv_mem [SET_COUNT];
    t_det               r_det_mem  [SET_COUNT];
    t_rrpv_row          r_rrpv_rd;
    t_det               r_det_rd;

    logic               mem_we, rd_en, out_ok;
    logic [SET_W-1:0]   mem_addr;
    t_rrpv_row          wr_row;
    t_det               wr_det;

    // datapath for the item in S_CALC
    logic [(1<<RRPV_W)-1:0] has_val;
    logic [RRPV_W-1:0]      top, gap, ins, bim_ins;
    logic [WAY_W-1:0]       victim, way;
    logic [WINDOW_BITS-1:0] stride;
    logic                   match, seen, use_bim;
    logic [STREAK_W-1:0]    new_streak;
    t_det                   det_new;
    t_rrpv_row              row_new;
    logic [SEL_W-1:0]       sel_upd;

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_ok      = ~r_out_valid | ~i_out_stall;

    // stride detector
    always_comb begin
        stride     = r_item.addr - r_det_rd.last_addr;
        match      = (r_det_rd.streak != '0) && (stride == r_det_rd.last_stride)
                     && (stride != '0);
        new_streak = STREAK_W'(1);
        if (match) begin
            new_streak = (r_det_rd.streak == STREAK_TOP) ? STREAK_TOP
                                                         : r_det_rd.streak + STREAK_W'(1);
        end
        seen                = match && (new_streak >= STREAK_W'(r_thr));
        det_new.last_addr   = r_item.addr;
        det_new.last_stride = match ? r_det_rd.last_stride : stride;
        det_new.streak      = new_streak;
    end

    // victim: lowest way holding the set's highest RRPV
    always_comb begin
        has_val = '0;
        for (int v = 0; v < (1 << RRPV_W); v++) begin
            for (int w = 0; w < WAY_COUNT; w++) begin
                if (r_rrpv_rd[w] == RRPV_W'(v)) begin
                    has_val[v] = 1'b1;
                end
            end
        end
        top = '0;
        for (int v = 0; v < (1 << RRPV_W); v++) begin
            if (has_val[v]) begin
                top = RRPV_W'(v);
            end
        end
        gap    = RRPV_TOP - top;
        victim = '0;
        for (int w = WAY_COUNT - 1; w >= 0; w--) begin
            if (r_rrpv_rd[w] == top) begin
                victim = WAY_W'(w);
            end
        end
    end

    // insertion policy and selector update
    always_comb begin
        bim_ins = (r_bim == '0) ? RRPV_LONG : RRPV_TOP;
        use_bim = 1'b0;
        sel_upd = r_sel;
        ins     = RRPV_LONG;
        if (r_item.is_hit) begin
            ins = RRPV_NEAR;
        end else if (seen) begin
            ins = RRPV_TOP;
        end else begin
            case (r_item.cls)
                CLS_SRRIP_LEAD: begin
                    ins = RRPV_LONG;
                    if (r_sel != '0) begin
                        sel_upd = r_sel - SEL_W'(1);
                    end
                end
                CLS_BRRIP_LEAD: begin
                    use_bim = 1'b1;
                    if (r_sel != SEL_TOP) begin
                        sel_upd = r_sel + SEL_W'(1);
                    end
                end
                CLS_FOLLOW: begin
                    use_bim = (r_sel < SEL_MID);
                end
                default: begin
                    ins = RRPV_LONG;
                end
            endcase
            if (use_bim) begin
                ins = bim_ins;
            end
        end

        way     = r_item.is_hit ? r_item.way : victim;
        row_new = r_rrpv_rd;
        if (!r_item.is_hit) begin
            for (int w = 0; w < WAY_COUNT; w++) begin
                row_new[w] = r_rrpv_rd[w] + gap;
            end
        end
        row_new[way] = ins;
    end

    // sequencer: clearing sweep, read, then compute/write
    always_comb begin
        n_state     = r_state;
        n_clr_idx   = r_clr_idx;
        n_item      = r_item;
        n_sel       = r_sel;
        n_bim       = r_bim;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;
        o_q_pop     = 1'b0;
        rd_en       = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = r_item.set;
        wr_row      = row_new;
        wr_det      = det_new;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_idx;
                wr_row    = '1;
                wr_det    = '0;
                n_clr_idx = r_clr_idx + SET_W'(1);
                if (r_clr_idx == SET_W'(SET_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    rd_en   = 1'b1;
                    n_item  = i_q_entry;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (out_ok) begin
                    mem_we                 = 1'b1;
                    n_out_valid            = 1'b1;
                    n_out.chosen_way       = 4'(way);
                    n_out.inserted_rrpv    = 2'(ins);
                    n_out.streaming_seen   = seen;
                    n_sel                  = sel_upd;
                    if (use_bim) begin
                        n_bim = r_bim + BIM_W'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_rrpv_mem[mem_addr] <= wr_row;
            r_det_mem[mem_addr]  <= wr_det;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rrpv_rd <= r_rrpv_mem[i_q_entry.set];
            r_det_rd  <= r_det_mem[i_q_entry.set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_sel       <= SEL_MID;
            r_bim       <= '0;
            r_thr       <= THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_sel       <= n_sel;
            r_bim       <= n_bim;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

>>> rtl/drrip_stream_bypass_replacement_core.sv
// DRRIP replacement core with stream bypass: top level.
// Depends on dsbr_pkg, dsbr_front, dsbr_queue, dsbr_back.
//
// Usage:
//  - Request channel (i_in_valid / o_in_stall / i_in_data): one cache access
//    per request: set, low address bits, hit flag, hit way.
//  - Result channel (o_out_valid / i_out_stall / o_out_data): one result per
//    request, in order: way filled or hit, RRPV written, streaming flag.
//  - Config (i_cfg_we / i_cfg_wdata): stream threshold, write when idle.
//  - Path: an accepted request enters the queue; the back end pops it and
//    reads the set's words, then computes and registers the result.
//  - The back end takes no new request until the read-modify-write of the
//    set's RRPV and stride-detector words is done (read, then update).
//  - A two-entry queue sits between the front end and the memory back end,
//    so requests are taken while a result waits in the output register.
//  - Reset: selector to midpoint, throttle counter to 0, threshold to 4; then
//    a clearing sweep writes each of the 2048 sets (RRPVs to max, detector
//    to zero). o_in_stall is high throughout the sweep.
//  - Receiver stall: the result holds in the output register; the back end
//    waits, the queue fills, and o_in_stall rises once it is full.
`default_nettype none

module drrip_stream_bypass_replacement_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [dsbr_pkg::THR_W-1:0] i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire                 dsbr_pkg::t_in_item i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output dsbr_pkg::t_out_item o_out_data
);
    import dsbr_pkg::*;

    logic     push, q_full, q_valid, q_pop, clearing;
    t_q_entry push_entry, head_entry;

    // classify and tag
    dsbr_front u_front (
        .i_in_data  (i_in_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // decouples front from the memory sequencer
    dsbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // memories, policy, output register
    dsbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> rtl/dsbr_checker.sv
// Port-level checks for the DRRIP core, bound to the top level.
// Depends on dsbr_pkg.
`default_nettype none

module dsbr_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input wire                 dsbr_pkg::t_out_item o_out_data
);
    import dsbr_pkg::*;

    // clearing sweep blocks requests right after reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during clearing sweep");

    // a streaming result is either a hit (0) or a distant fill (max)
    a_stream_rrpv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.streaming_seen |->
            (o_out_data.inserted_rrpv == RRPV_TOP) ||
            (o_out_data.inserted_rrpv == RRPV_NEAR))
        else $error("streaming result with wrong RRPV");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind drrip_stream_bypass_replacement_core dsbr_checker u_dsbr_checker (.*);

`default_nettype wire

>>> dv/drrip_stream_bypass_replacement_core_tb.sv
// Self-checking testbench for drrip_stream_bypass_replacement_core.
// Depends on dsbr_pkg and the core RTL. A built-in replacement predictor
// tracks RRPVs, stride detectors, the dueling selector and the BRRIP throttle.
module drrip_stream_bypass_replacement_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsbr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 7;
    localparam int PHASE_REQS   = 205;
    localparam int DRAIN_CYCLES = 8;

    // Leader and follower sets that the random part keeps returning to, so
    // that sets fill up, age and get victimized repeatedly.
    localparam logic [3:0][SET_W-1:0] SRRIP_SETS  = {11'd31, 11'd17, 11'd1, 11'd0};
    localparam logic [3:0][SET_W-1:0] BRRIP_SETS  = {11'd63, 11'd48, 11'd33, 11'd32};
    localparam logic [3:0][SET_W-1:0] FOLLOW_SETS = {11'd2047, 11'd1024, 11'd100, 11'd64};

    // Which kind of set the random traffic leans toward: pushing the selector
    // down (SRRIP leaders) or up (BRRIP leaders) moves followers across policies.
    typedef enum logic [1:0] {
        MIX_ALL,
        MIX_SRRIP,
        MIX_BRRIP
    } t_mix;

    // DUT-facing signals; the inputs are known from time zero
    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [THR_W-1:0]  cfg_wdata = '0;
    logic              in_valid  = 1'b0;
    t_in_item          in_data   = '0;
    logic              out_stall = 1'b0;
    logic              in_stall;
    logic              out_valid;
    t_out_item         out_data;

    // Predictor state
    logic [RRPV_W-1:0]      way_age    [SET_COUNT][WAY_COUNT];
    logic [WINDOW_BITS-1:0] det_addr   [SET_COUNT];
    logic [WINDOW_BITS-1:0] det_stride [SET_COUNT];
    logic [STREAK_W-1:0]    det_streak [SET_COUNT];
    logic [SEL_W-1:0]       duel_sel;
    logic [BIM_W-1:0]       throttle;
    logic [THR_W-1:0]       threshold;

    // Generator's view of the last address per set (mirrors request order)
    logic [WINDOW_BITS-1:0] gen_addr [SET_COUNT];

    t_in_item    req_backlog[$];       // requests waiting for the driver
    t_out_item   expected_results[$];  // predicted results, oldest first
    t_out_item   want;

    bit          idle_on = 1'b1;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned reqs_sent = 0;
    int unsigned stream_results = 0;
    int unsigned bimodal_fills = 0;
    logic [SEL_W-1:0] sel_low = SEL_MID;
    logic [SEL_W-1:0] sel_high = SEL_MID;

    drrip_stream_bypass_replacement_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 i_clk = ~i_clk;

    // One cache access through the predictor: detector first (hits and misses
    // alike), then either promote the hit way or age the set and fill a victim.
    function automatic t_out_item predict_replacement(input t_in_item req);
        t_out_item              res;
        logic [SET_W-1:0]       s;
        logic [WINDOW_BITS-1:0] stride;
        logic [RRPV_W-1:0]      oldest;
        logic [RRPV_W-1:0]      ins;
        logic [WAY_W-1:0]       way;
        logic                   seen;
        logic                   use_bim;
        s       = req.set_index;
        stride  = req.address_low - det_addr[s];
        seen    = 1'b0;
        use_bim = 1'b0;
        ins     = RRPV_LONG;
        if (det_streak[s] != '0 && stride == det_stride[s] && stride != '0) begin
            if (det_streak[s] != STREAK_TOP) begin
                det_streak[s] = det_streak[s] + STREAK_W'(1);
            end
            seen = (det_streak[s] >= STREAK_W'(threshold));
        end else begin
            det_stride[s] = stride;
            det_streak[s] = STREAK_W'(1);
        end
        det_addr[s] = req.address_low;

        if (req.is_hit) begin
            way = req.hit_way;
            ins = RRPV_NEAR;
        end else begin
            // age until some way is distant, victim is the lowest such way
            oldest = '0;
            for (int w = 0; w < WAY_COUNT; w++) begin
                if (way_age[s][w] > oldest) oldest = way_age[s][w];
            end
            for (int w = 0; w < WAY_COUNT; w++) begin
                way_age[s][w] = way_age[s][w] + (RRPV_TOP - oldest);
            end
            way = '0;
            for (int w = WAY_COUNT - 1; w >= 0; w--) begin
                if (way_age[s][w] == RRPV_TOP) way = WAY_W'(w);
            end
            // streaming sets bypass dueling entirely
            if (seen) begin
                ins = RRPV_TOP;
            end else if (s < SET_W'(LEAD_HALF)) begin
                if (duel_sel != '0) duel_sel = duel_sel - SEL_W'(1);
            end else if (s < SET_W'(LEADER_COUNT)) begin
                use_bim = 1'b1;
                if (duel_sel != SEL_TOP) duel_sel = duel_sel + SEL_W'(1);
            end else if (duel_sel < SEL_MID) begin
                use_bim = 1'b1;
            end
            // BRRIP: long re-reference only on every 32nd fill
            if (use_bim) begin
                ins = (throttle == '0) ? RRPV_LONG : RRPV_TOP;
                throttle = throttle + BIM_W'(1);
                bimodal_fills++;
            end
        end
        way_age[s][way] = ins;

        res.chosen_way     = way;
        res.inserted_rrpv  = ins;
        res.streaming_seen = seen;
        return res;
    endfunction

    task automatic push_req(input logic [SET_W-1:0] s, input logic [WINDOW_BITS-1:0] addr,
                            input logic hit, input logic [WAY_W-1:0] way);
        t_in_item r;
        r.set_index   = s;
        r.address_low = addr;
        r.is_hit      = hit;
        r.hit_way     = way;
        req_backlog.push_back(r);
        gen_addr[s] = addr;
    endtask

    function automatic logic [SET_W-1:0] pick_set(input t_mix mix);
        int unsigned r;
        int unsigned s_cut;
        int unsigned b_cut;
        r = $urandom_range(0, 9);
        case (mix)
            MIX_SRRIP: begin
                s_cut = 6;
                b_cut = 7;
            end
            MIX_BRRIP: begin
                s_cut = 1;
                b_cut = 7;
            end
            default: begin
                s_cut = 3;
                b_cut = 6;
            end
        endcase
        if (r < s_cut) return SRRIP_SETS[$urandom_range(0, 3)];
        if (r < b_cut) return BRRIP_SETS[$urandom_range(0, 3)];
        if (r < 9)     return FOLLOW_SETS[$urandom_range(0, 3)];
        return SET_W'($urandom_range(0, SET_COUNT - 1));
    endfunction

    // Mostly strided runs (what the detector needs to see), with random single
    // accesses, zero strides and runs broken off by a stray address.
    task automatic gen_phase(input int unsigned count, input t_mix mix);
        int unsigned            made;
        int unsigned            run;
        logic [SET_W-1:0]       s;
        logic [WINDOW_BITS-1:0] step;
        made = 0;
        while (made < count) begin
            s = pick_set(mix);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    run  = $urandom_range(3, 10);
                    step = ($urandom_range(0, 3) == 0) ? WINDOW_BITS'($urandom)
                                                       : WINDOW_BITS'($urandom_range(1, 64) << 6);
                    for (int k = 0; k < run; k++) begin
                        push_req(s, gen_addr[s] + step, $urandom_range(0, 4) == 0,
                                 WAY_W'($urandom));
                    end
                    made += run;
                end
                5, 6, 7: begin
                    push_req(s, WINDOW_BITS'($urandom), $urandom_range(0, 4) < 2,
                             WAY_W'($urandom));
                    made += 1;
                end
                8: begin
                    push_req(s, gen_addr[s], 1'($urandom_range(0, 1)), WAY_W'($urandom));
                    made += 1;
                end
                default: begin
                    step = WINDOW_BITS'($urandom_range(1, 4096));
                    push_req(s, gen_addr[s] + step, 1'b0, WAY_W'($urandom));
                    push_req(s, gen_addr[s] + step, 1'b0, WAY_W'($urandom));
                    push_req(s, WINDOW_BITS'($urandom), 1'b0, WAY_W'($urandom));
                    made += 3;
                end
            endcase
        end
    endtask

    // Quiet means: nothing queued, nothing on the request channel, nothing owed.
    task automatic wait_quiet();
        while (req_backlog.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic flag_field(input string field, input logic [3:0] want_v,
                              input logic [3:0] got_v);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        errors++;
    endtask

    // Request driver: predicts each request as it is accepted, then loads the
    // next one or idles for a random burst.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expected_results.push_back(predict_replacement(in_data));
                reqs_sent++;
                if (duel_sel < sel_low)  sel_low  = duel_sel;
                if (duel_sel > sel_high) sel_high = duel_sel;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= req_backlog.pop_front();
                    if (idle_on && $urandom_range(0, 9) == 0) begin
                        send_gap = $urandom_range(1, 19);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0b",
                             $time, out_data.chosen_way, out_data.inserted_rrpv,
                             out_data.streaming_seen);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_data.chosen_way !== want.chosen_way)
                        flag_field("chosen_way", want.chosen_way, out_data.chosen_way);
                    if (out_data.inserted_rrpv !== want.inserted_rrpv)
                        flag_field("inserted_rrpv", 4'(want.inserted_rrpv),
                                   4'(out_data.inserted_rrpv));
                    if (out_data.streaming_seen !== want.streaming_seen)
                        flag_field("streaming_seen", 4'(want.streaming_seen),
                                   4'(out_data.streaming_seen));
                    if (want.streaming_seen) stream_results++;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 18);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned thr_plan [PHASES];
        t_mix        mix_plan [PHASES];
        // thresholds 0 and 1 lie below any streak a match can reach and must still work
        thr_plan = '{7, 2, 0, 1, 5, 3, 6};
        mix_plan = '{MIX_ALL, MIX_SRRIP, MIX_SRRIP, MIX_BRRIP, MIX_BRRIP, MIX_ALL, MIX_ALL};

        threshold = THR_RESET;
        duel_sel  = SEL_MID;
        throttle  = '0;
        for (int s = 0; s < SET_COUNT; s++) begin
            for (int w = 0; w < WAY_COUNT; w++) way_age[s][w] = RRPV_TOP;
            det_addr[s]   = '0;
            det_stride[s] = '0;
            det_streak[s] = '0;
            gen_addr[s]   = '0;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, reset threshold (4). The driver holds off on its own
        // while the clearing sweep keeps the request channel stalled.
        @(negedge i_clk);
        push_req(11'd0,    20'h00000, 1'b0, 4'd0);   // zero stride, SRRIP leader
        push_req(11'd0,    20'hFFFFF, 1'b0, 4'd0);   // address all ones
        push_req(11'd0,    20'hFFFFF, 1'b1, 4'd15);  // hit on top way
        push_req(11'd2047, 20'h12345, 1'b1, 4'd0);   // hit on way 0, top set
        push_req(11'd2047, 20'hAAAAA, 1'b0, 4'd5);
        push_req(11'd2047, 20'h55555, 1'b0, 4'd10);
        push_req(11'd32,   20'h00100, 1'b0, 4'd0);   // first BRRIP leader fill: throttled
        push_req(11'd33,   20'h00200, 1'b0, 4'd0);   // throttled BRRIP fill
        push_req(11'd100,  20'h00040, 1'b0, 4'd0);   // follower
        for (int k = 1; k <= 6; k++) begin
            push_req(11'd40, WINDOW_BITS'(k * 'h40), 1'b0, 4'd0);  // becomes streaming
        end
        push_req(11'd40,   20'h001C0, 1'b1, 4'd7);   // streaming hit
        push_req(11'd40,   20'h001C0, 1'b0, 4'd0);   // zero stride breaks the streak
        push_req(11'd5,    20'hFFFE0, 1'b0, 4'd0);
        for (int k = 0; k < 4; k++) begin
            push_req(11'd5, gen_addr[5] + 20'h30, 1'b0, 4'd0);     // stride wraps the window
        end
        push_req(11'd31,   20'h0BEEF, 1'b0, 4'd0);   // last SRRIP leader
        push_req(11'd63,   20'h0CAFE, 1'b0, 4'd0);   // last BRRIP leader
        push_req(11'd64,   20'h0F00D, 1'b0, 4'd0);   // first follower
        push_req(11'd1024, 20'h80000, 1'b1, 4'd8);

        // Random phases, each under its own threshold, written while quiet.
        for (int p = 0; p < PHASES; p++) begin
            wait_quiet();
            @(posedge i_clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= THR_W'(thr_plan[p]);
            @(posedge i_clk);
            cfg_we    <= 1'b0;
            threshold = THR_W'(thr_plan[p]);
            idle_on   = (p != PHASES - 1);   // last phase runs back to back
            @(negedge i_clk);
            gen_phase(PHASE_REQS, mix_plan[p]);
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d cache accesses under %0d stream thresholds plus the reset value",
                 reqs_sent, PHASES);
        $display("%0d streaming results, %0d BRRIP fills, dueling selector spanned %0d..%0d",
                 stream_results, bimodal_fills, sel_low, sel_high);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
